/* rtl/core/mss_pkg.sv */
// Package for the maximum sub-rectangle sum block: field widths, register reset
// value, controller states and the control word passed to the strip unit.
// Depends on nothing.
`default_nettype none

package mss_pkg;

  localparam int ELEM_W = 8;
  localparam int SIZE_W = 8;
  localparam int OUT_W  = 22;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 8'd4;

  typedef enum logic [3:0] {
    ST_LOAD   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  // One search step as issued to the strip unit.
  typedef struct packed {
    logic valid;
    logic first_row;   // bottom row equals top row: strip starts afresh
    logic first_col;   // column zero: Kadane run restarts
    logic first_all;   // very first step of the search: best sum is seeded
  } strip_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/mss_strip_unit.sv */
// Column strip accumulator and Kadane scan for the maximum sub-rectangle sum.
// Holds the column strip sums memory and the running and best sums.
// Depends on mss_pkg.
`default_nettype none

module mss_strip_unit #(
  parameter int MAX_SIDE = 128
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire mss_pkg::strip_ctrl_t        ctrl_i,
  input  wire [((MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1)-1:0] col_i,
  input  wire signed [mss_pkg::ELEM_W-1:0] elem_i,   // arrives in the cycle after ctrl_i
  output logic signed [mss_pkg::OUT_W-1:0] best_o
);

  localparam int COL_W   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int STRIP_W = mss_pkg::ELEM_W + $clog2(MAX_SIDE);
  localparam int SUM_W   = mss_pkg::ELEM_W + 2 * $clog2(MAX_SIDE);

  logic signed [STRIP_W-1:0] strip_mem [MAX_SIDE];
  logic signed [STRIP_W-1:0] strip_rd_r;
  mss_pkg::strip_ctrl_t      c1_r;
  logic [COL_W-1:0]          col1_r;

  logic signed [SUM_W-1:0]   run_r, run_nxt;
  logic signed [SUM_W-1:0]   best_r, best_nxt;
  logic signed [STRIP_W-1:0] strip_new;

  // The same column is read again only after every other column of the row, so
  // a read never meets a pending write unless n is one, and then the strip is
  // always restarted and the read data is not used.
  always_ff @(posedge clk) begin
    strip_rd_r <= strip_mem[col_i];
    col1_r     <= col_i;
    if (c1_r.valid) begin
      strip_mem[col1_r] <= strip_new;
    end
  end

  always_comb begin
    strip_new = STRIP_W'(elem_i) + (c1_r.first_row ? STRIP_W'(0) : strip_rd_r);
    if (c1_r.first_col || run_r < 0) begin
      run_nxt = SUM_W'(strip_new);
    end else begin
      run_nxt = run_r + SUM_W'(strip_new);
    end
    if (c1_r.first_all || run_nxt > best_r) begin
      best_nxt = run_nxt;
    end else begin
      best_nxt = best_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r   <= '0;
      run_r  <= '0;
      best_r <= '0;
    end else begin
      c1_r <= ctrl_i;
      if (c1_r.valid) begin
        run_r  <= run_nxt;
        best_r <= best_nxt;
      end
    end
  end

  assign best_o = mss_pkg::OUT_W'(best_r);

  a_no_stale_strip: assert property (@(posedge clk) disable iff (!rst_n)
    (c1_r.valid && ctrl_i.valid && col1_r == col_i) |-> ctrl_i.first_row)
    else $error("strip read meets a pending write of the same column");

  a_seed_best: assert property (@(posedge clk) disable iff (!rst_n)
    (c1_r.valid && c1_r.first_all) |=> (best_r == run_r))
    else $error("best sum not seeded by the first step");

  a_best_bounds_run: assert property (@(posedge clk) disable iff (!rst_n)
    c1_r.valid |=> (best_r >= run_r))
    else $error("best sum fell below the running sum");

endmodule

`default_nettype wire

/* rtl/core/max_submatrix_sum.sv */
// Top level of the maximum sub-rectangle sum block: element store, search
// sequencer and result register. Depends on mss_pkg and mss_strip_unit.
`default_nettype none

// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+------------------------------
// in        | input     | in_valid / in_stall  | in_element_value (8b signed)
// out       | output    | out_valid / out_stall| out_max_sum (22b signed)
// cfg       | input     | cfg_wr_en            | cfg_wr_data (8b, matrix side)
//
// Elements are taken one per cycle into the element memory until n*n have
// arrived. The search then runs one step per cycle, n * n*(n+1)/2 steps set by
// the single read port of the element memory, then drains the strip unit and
// hands over the result (ST_DRAIN, ST_DONE); input is stalled throughout.
// If the previous result is still held, the hand-over waits and input stays
// stalled until that result is taken.
// Reset is synchronous and active low; no memory is cleared, so none needs a
// clearing pass. A waiting result does not hold up loading of the next matrix.

module max_submatrix_sum #(
  parameter int MAX_SIDE = 128
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_wr_en,
  input  wire [mss_pkg::SIZE_W-1:0]        cfg_wr_data,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire signed [mss_pkg::ELEM_W-1:0] in_element_value,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic signed [mss_pkg::OUT_W-1:0] out_max_sum
);

  localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int COL_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);

  mss_pkg::state_t state_r, state_nxt;

  logic [mss_pkg::SIZE_W-1:0] size_r;
  logic [SIDE_W-1:0]          side;
  logic [CNT_W-1:0]           total;
  logic [COL_W-1:0]           last_idx;

  logic [CNT_W-1:0]  load_r, load_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [COL_W-1:0]  bot_r, bot_nxt;
  logic [COL_W-1:0]  top_r, top_nxt;
  logic [ADDR_W-1:0] row_base_r, row_base_nxt;
  logic [ADDR_W-1:0] top_base_r, top_base_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic signed [mss_pkg::OUT_W-1:0] out_sum_r, out_sum_nxt;

  logic signed [mss_pkg::ELEM_W-1:0] mat_mem [DEPTH];
  logic signed [mss_pkg::ELEM_W-1:0] elem_rd_r;
  logic [ADDR_W-1:0]                 rd_addr;

  mss_pkg::strip_ctrl_t              sctrl;
  logic signed [mss_pkg::OUT_W-1:0]  best;

  logic in_take;
  logic last_step;

  // A side of zero counts as one, and a side above the store's capacity is
  // clamped to it.
  always_comb begin
    if (size_r == '0) begin
      side = SIDE_W'(1);
    end else if (32'(size_r) > MAX_SIDE) begin
      side = SIDE_W'(MAX_SIDE);
    end else begin
      side = SIDE_W'(size_r);
    end
    total    = CNT_W'(32'(side) * 32'(side));
    last_idx = COL_W'(side - SIDE_W'(1));
  end

  assign in_take   = in_valid && !in_stall;
  assign in_stall  = (state_r != mss_pkg::ST_LOAD);
  assign last_step = (col_r == last_idx) && (bot_r == last_idx) && (top_r == last_idx);
  assign rd_addr   = row_base_r + ADDR_W'(col_r);

  // Element memory: written while loading, read once per search step.
  always_ff @(posedge clk) begin
    if (in_take) begin
      mat_mem[load_r[ADDR_W-1:0]] <= in_element_value;
    end
    elem_rd_r <= mat_mem[rd_addr];
  end

  always_comb begin
    sctrl.valid     = (state_r == mss_pkg::ST_SEARCH);
    sctrl.first_row = (bot_r == top_r);
    sctrl.first_col = (col_r == '0);
    sctrl.first_all = (top_r == '0) && (bot_r == '0) && (col_r == '0);
  end

  mss_strip_unit #(
    .MAX_SIDE (MAX_SIDE)
  ) u_strip (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl_i (sctrl),
    .col_i  (col_r),
    .elem_i (elem_rd_r),
    .best_o (best)
  );

  // Sequencer: the strip loops over top row, bottom row and column.
  always_comb begin
    state_nxt     = state_r;
    load_nxt      = load_r;
    col_nxt       = col_r;
    bot_nxt       = bot_r;
    top_nxt       = top_r;
    row_base_nxt  = row_base_r;
    top_base_nxt  = top_base_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_sum_nxt   = out_sum_r;

    unique case (state_r)
      mss_pkg::ST_LOAD: begin
        if (in_take) begin
          if (load_r + CNT_W'(1) == total) begin
            load_nxt     = '0;
            state_nxt    = mss_pkg::ST_SEARCH;
            col_nxt      = '0;
            bot_nxt      = '0;
            top_nxt      = '0;
            row_base_nxt = '0;
            top_base_nxt = '0;
          end else begin
            load_nxt = load_r + CNT_W'(1);
          end
        end
        // A side write throws away any partial matrix.
        if (cfg_wr_en) begin
          load_nxt = '0;
        end
      end
      mss_pkg::ST_SEARCH: begin
        if (last_step) begin
          state_nxt = mss_pkg::ST_DRAIN;
        end else if (col_r != last_idx) begin
          col_nxt = col_r + COL_W'(1);
        end else if (bot_r != last_idx) begin
          col_nxt      = '0;
          bot_nxt      = bot_r + COL_W'(1);
          row_base_nxt = row_base_r + ADDR_W'(side);
        end else begin
          col_nxt      = '0;
          top_nxt      = top_r + COL_W'(1);
          bot_nxt      = top_r + COL_W'(1);
          top_base_nxt = top_base_r + ADDR_W'(side);
          row_base_nxt = top_base_r + ADDR_W'(side);
        end
      end
      mss_pkg::ST_DRAIN: begin
        state_nxt = mss_pkg::ST_DONE;
      end
      mss_pkg::ST_DONE: begin
        // Wait here only if the previous result has not been taken yet.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = best;
          state_nxt     = mss_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = mss_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mss_pkg::ST_LOAD;
      size_r      <= mss_pkg::SIZE_RESET;
      load_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_r      <= load_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        size_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    col_r      <= col_nxt;
    bot_r      <= bot_nxt;
    top_r      <= top_nxt;
    row_base_r <= row_base_nxt;
    top_base_r <= top_base_nxt;
    out_sum_r  <= out_sum_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_max_sum = out_sum_r;

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == mss_pkg::ST_DONE))
    else $error("result raised outside the hand-over state");

  a_loop_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mss_pkg::ST_SEARCH) |->
      (32'(col_r) < 32'(side) && 32'(bot_r) < 32'(side) && top_r <= bot_r))
    else $error("search counters out of range");

  a_row_base: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mss_pkg::ST_SEARCH) |->
      (32'(row_base_r) == 32'(bot_r) * 32'(side) &&
       32'(top_base_r) == 32'(top_r) * 32'(side)))
    else $error("row base address out of step with row counters");

endmodule

`default_nettype wire
